FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants for the sorted priority queue
// Item formats, operation and status codes and the control bundle that
// joins the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 16;                          // queue slots, 2..31
  localparam int CNT_W = $clog2(DEPTH + 1);           // holds 0..DEPTH
  localparam int CFG_W = 5;                           // capacity register
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ECNT_W = 5;                          // entry_count field
  localparam int DATA_W = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OVERFLOW  = 2'd1,
    STS_UNDERFLOW = 2'd2,
    STS_RSVD      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP,
    OP_CLEAR
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] data_value;
    logic signed [31:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] head_value;
    logic               not_empty;
    logic               is_full;
    logic [4:0]         entry_count;
    status_t            status;
  } out_item_t;

  // controller -> datapath command
  typedef struct packed {
    logic load;   // execute op and capture result this edge
    op_t  op;
  } cmd_t;

endpackage

FILE: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl - handshake controller for the sorted priority queue
// Decodes the operation, issues one datapath command per accepted item and
// tracks the result register.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  spq_pkg::func_t  in_func,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output spq_pkg::cmd_t   cmd
);
  import spq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    // result register may refill on the edge it drains
    in_stall  = (state_r == ST_HOLD) && out_stall;
    out_valid = (state_r == ST_HOLD);
    accept    = in_valid && !in_stall;
    state_nxt = state_r;
    cmd.load  = accept;
    case (in_func)
      FN_PUSH:  cmd.op = OP_PUSH;
      FN_POP:   cmd.op = OP_POP;
      FN_CLEAR: cmd.op = OP_CLEAR;
      default:  cmd.op = OP_NONE;
    endcase
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!accept && !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: design/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath - sorted register chain of the priority queue
// Each slot compares its priority with the incoming one and shifts, loads or
// holds; pop shifts the chain toward the front. Result register included.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spq_pkg::cmd_t                cmd,
  input  spq_pkg::in_item_t            in_item,
  input  logic                         cfg_we,
  input  logic [spq_pkg::CFG_W-1:0]    cfg_wdata,
  output spq_pkg::out_item_t           out_item
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] val_r [DEPTH];
  logic signed [DATA_W-1:0] pri_r [DEPTH];
  logic signed [DATA_W-1:0] val_nxt [DEPTH];
  logic signed [DATA_W-1:0] pri_nxt [DEPTH];
  logic signed [DATA_W-1:0] val_prev [DEPTH];
  logic signed [DATA_W-1:0] pri_prev [DEPTH];
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CFG_W-1:0]         cap_r;
  out_item_t                res_r, res_nxt;

  logic [DEPTH-1:0]         gt;        // slot is valid and ranks behind new item
  logic [DEPTH:0]           gt_below;  // gt of the slot in front
  logic [LIM_W-1:0]         cap_ext, lim, cnt_ext, cnt_nxt_ext;
  logic signed [DATA_W-1:0] popped;
  status_t                  sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      if (cmd.load) count_r <= count_nxt;
      if (cfg_we)   cap_r   <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= res_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        val_r[i] <= val_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
    end
  end

  always_comb begin
    cap_ext = LIM_W'(cap_r);
    if (cap_ext == '0) begin
      lim = LIM_W'(1);
    end else if (cap_ext > LIM_W'(DEPTH)) begin
      lim = LIM_W'(DEPTH);
    end else begin
      lim = cap_ext;
    end
    cnt_ext = LIM_W'(count_r);

    gt_below[0] = 1'b0;
    val_prev[0] = in_item.data_value;
    pri_prev[0] = in_item.priority_req;
    for (int i = 0; i < DEPTH; i++) begin
      gt[i]         = (CNT_W'(i) < count_r) && (pri_r[i] > in_item.priority_req);
      gt_below[i+1] = gt[i];
    end
    for (int i = 1; i < DEPTH; i++) begin
      val_prev[i] = val_r[i-1];
      pri_prev[i] = pri_r[i-1];
    end

    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
    end
    count_nxt = count_r;
    popped    = '0;
    sts       = STS_OK;

    case (cmd.op)
      OP_PUSH: begin
        if (cnt_ext >= lim) begin
          sts = STS_OVERFLOW;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (gt_below[i]) begin
              val_nxt[i] = val_prev[i];
              pri_nxt[i] = pri_prev[i];
            end else if (gt[i] || (CNT_W'(i) == count_r)) begin
              val_nxt[i] = in_item.data_value;
              pri_nxt[i] = in_item.priority_req;
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          sts = STS_UNDERFLOW;
        end else begin
          popped = val_r[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            val_nxt[i] = val_r[i+1];
            pri_nxt[i] = pri_r[i+1];
          end
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase

    cnt_nxt_ext          = LIM_W'(count_nxt);
    res_nxt.popped_value = popped;
    res_nxt.head_value   = (count_nxt != '0) ? val_nxt[0] : '0;
    res_nxt.not_empty    = (count_nxt != '0);
    res_nxt.is_full      = (cnt_nxt_ext >= lim);
    res_nxt.entry_count  = ECNT_W'(count_nxt);
    res_nxt.status       = sts;
  end

  assign out_item = res_r;

endmodule

FILE: design/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top - bounded priority queue with sorted insert
// Push, pop and clear on a queue ordered by ascending signed priority, one
// result item per operation.
// ----------------------------------------------------------------------------
// The queue holds up to spq_pkg::DEPTH entries in a chain of registers kept
// sorted by priority (smallest number at the front, ties in arrival order).
// Every accepted item (push, pop, clear, or the unused code as a no-op)
// completes at its acceptance edge: all slots compare against the new priority in
// parallel and shift, load or hold at that edge, so the rate is one item
// per cycle while out_stall does not hold the result register. The result
// sits in an output register from the cycle after acceptance; a new item is taken
// while that result is being taken, and in_stall rises only while a result
// waits under out_stall. cfg_wdata sets the capacity limit (0 acts as 1,
// values above DEPTH act as DEPTH); write it only while the queue is idle.
// Reset empties the queue and sets the limit to 16; no clearing pass is run.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // operation items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  spq_pkg::in_item_t          in_item,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output spq_pkg::out_item_t         out_item,
  // capacity limit register
  input  logic                       cfg_we,
  input  logic [spq_pkg::CFG_W-1:0]  cfg_wdata
);
  import spq_pkg::*;

  cmd_t cmd;

  // controller: handshake and op decode
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_item.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: sorted slot chain, limit register, result register
  spq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

  // count never runs past the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.entry_count <= ECNT_W'(DEPTH)))
    else $error("entry count beyond depth");

  // flag and count agree
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.not_empty == (out_item.entry_count != '0)))
    else $error("not_empty disagrees with count");

  // a dropped push only happens on a full queue
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STS_OVERFLOW) |-> out_item.is_full)
    else $error("overflow while not full");

  // underflow leaves nothing popped and an empty queue
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STS_UNDERFLOW)
      |-> (!out_item.not_empty && out_item.popped_value == '0))
    else $error("underflow on non-empty queue");

endmodule

FILE: sim/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker - result checker for the sorted priority queue
// Watches the operation, result and capacity ports, keeps its own sorted
// queue to predict every result item and compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spq_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  spq_pkg::in_item_t         in_item,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  spq_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [spq_pkg::CFG_W-1:0] cfg_wdata,
  output int                        mismatches,
  output int                        pending
);
  import spq_pkg::*;

  logic signed [31:0] slot_val  [DEPTH];
  logic signed [31:0] slot_prio [DEPTH];
  int                 held;
  logic [CFG_W-1:0]   cap_limit;
  out_item_t          expected_q [$];

  // 0 acts as 1, anything above DEPTH acts as DEPTH
  function automatic int eff_limit();
    if (cap_limit == '0) return 1;
    if (int'(cap_limit) > DEPTH) return DEPTH;
    return int'(cap_limit);
  endfunction

  // Apply one operation to the shadow queue, return the result it yields.
  function automatic out_item_t apply_op(input in_item_t op);
    out_item_t r;
    int        lim;
    int        pos;
    int        i;
    r   = '0;
    lim = eff_limit();
    r.status = STS_OK;
    case (op.func)
      FN_PUSH: begin
        if (held >= lim) begin
          r.status = STS_OVERFLOW;
        end else begin
          // new entry goes behind every entry of equal or smaller priority
          pos = 0;
          while (pos < held && !(slot_prio[pos] > op.priority_req)) pos++;
          for (i = held; i > pos; i--) begin
            slot_val[i]  = slot_val[i-1];
            slot_prio[i] = slot_prio[i-1];
          end
          slot_val[pos]  = op.data_value;
          slot_prio[pos] = op.priority_req;
          held++;
        end
      end
      FN_POP: begin
        if (held == 0) begin
          r.status = STS_UNDERFLOW;
        end else begin
          r.popped_value = slot_val[0];
          for (i = 1; i < held; i++) begin
            slot_val[i-1]  = slot_val[i];
            slot_prio[i-1] = slot_prio[i];
          end
          held--;
        end
      end
      FN_CLEAR: held = 0;
      default: ;
    endcase
    r.head_value  = (held > 0) ? slot_val[0] : '0;
    r.not_empty   = (held > 0);
    r.is_full     = (held >= lim);
    r.entry_count = 5'(held);
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t: result mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held       = 0;
      cap_limit  = CAP_RESET;
      mismatches = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) cap_limit = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("result item with no operation outstanding");
        end else begin
          out_item_t want;
          want = expected_q.pop_front();
          if (out_item.popped_value !== want.popped_value)
            report($sformatf("popped_value %h, want %h", out_item.popped_value,
                             want.popped_value));
          if (out_item.head_value !== want.head_value)
            report($sformatf("head_value %h, want %h", out_item.head_value,
                             want.head_value));
          if (out_item.not_empty !== want.not_empty)
            report($sformatf("not_empty %b, want %b", out_item.not_empty,
                             want.not_empty));
          if (out_item.is_full !== want.is_full)
            report($sformatf("is_full %b, want %b", out_item.is_full, want.is_full));
          if (out_item.entry_count !== want.entry_count)
            report($sformatf("entry_count %0d, want %0d", out_item.entry_count,
                             want.entry_count));
          if (out_item.status !== want.status)
            report($sformatf("status %0d, want %0d", out_item.status, want.status));
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(apply_op(in_item));
    end
    // registered, so the stimulus never reads a half-updated count
    pending <= expected_q.size();
  end

endmodule

FILE: sim/sorted_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb - testbench for the sorted priority queue
// Directed corner operations, then phases of random push/pop/clear traffic
// under several capacity limits with random idle bursts on both channels.
// Results are checked item by item by spq_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_priority_queue_top_tb;
  import spq_pkg::*;

  localparam int QUIET_LIMIT = 1000;   // cycles with no handshake before giving up
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 9;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int quiet_cycles;

  // idle bursts on the operation side and the result side
  bit src_gaps;
  bit snk_gaps;

  always #5 clk = ~clk;

  sorted_priority_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  spq_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sorted_priority_queue_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts while snk_gaps is set.
  // Each step carries at most one assignment to out_stall.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (snk_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  function automatic in_item_t make_item(input func_t f, input logic [31:0] v,
                                         input logic [31:0] p);
    in_item_t it;
    it.func         = f;
    it.data_value   = v;
    it.priority_req = p;
    return it;
  endfunction

  // Random operation; lean 0 balanced, 1 filling, 2 draining.
  // Priorities mix a narrow band (lots of ties), the extremes and full range.
  function automatic in_item_t random_op(input int lean);
    in_item_t    it;
    int          roll;
    int          push_pct;
    logic [31:0] p;
    push_pct = (lean == 1) ? 70 : (lean == 2) ? 25 : 45;
    roll     = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       p = 32'($urandom_range(0, 6)) - 32'd3;
      1: begin
        case ($urandom_range(0, 3))
          0:       p = 32'h8000_0000;
          1:       p = 32'h7fff_ffff;
          2:       p = 32'h0000_0000;
          default: p = 32'hffff_ffff;
        endcase
      end
      default: p = $urandom;
    endcase
    if (roll < push_pct)  it = make_item(FN_PUSH, $urandom, p);
    else if (roll < 94)   it = make_item(FN_POP, $urandom, p);
    else if (roll < 97)   it = make_item(FN_CLEAR, $urandom, p);
    else                  it = make_item(FN_NOP, $urandom, p);
    return it;
  endfunction

  // Present one item and hold it until accepted. An optional idle burst
  // goes in front; in_valid stays high between back-to-back items.
  task automatic send_item(input in_item_t it);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every result item has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Register writes happen only with the queue drained and quiet.
  task automatic set_limit(input logic [CFG_W-1:0] lim);
    drain();
    repeat (2) @(posedge clk);
    cfg_wdata <= lim;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Limits per random phase: reset value, both out-of-range ends (0 and 31),
  // the minimum, and a few in between. Phases do not clear the queue, so a
  // drop from a high limit to a low one can leave the count above the limit.
  int phase_limit [NUM_PHASES] = '{16, 1, 0, 31, 5, 20, 2, 9, 16};

  initial begin
    int lean;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    src_gaps  = 1'b1;
    snk_gaps  = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corners, reset limit of 16 ----
    send_item(make_item(FN_POP, 32'hdead_beef, 32'h0));          // underflow
    send_item(make_item(FN_NOP, 32'h1234_5678, 32'h1));          // no-op on empty
    send_item(make_item(FN_PUSH, 32'h7fff_ffff, 32'h7fff_ffff)); // into empty queue
    send_item(make_item(FN_PUSH, 32'h8000_0000, 32'h8000_0000)); // new front
    // equal priorities must leave in arrival order
    send_item(make_item(FN_PUSH, 32'd1, 32'd5));
    send_item(make_item(FN_PUSH, 32'd2, 32'd5));
    send_item(make_item(FN_PUSH, 32'd3, 32'd5));
    send_item(make_item(FN_PUSH, 32'hffff_ffff, 32'hffff_ffff));
    send_item(make_item(FN_PUSH, 32'd0, 32'd0));
    send_item(make_item(FN_NOP, 32'hffff_ffff, 32'hffff_ffff));  // no-op, non-empty
    repeat (4) send_item(make_item(FN_POP, 32'h0, 32'h0));
    send_item(make_item(FN_CLEAR, 32'h5555_aaaa, 32'haaaa_5555));
    send_item(make_item(FN_POP, 32'h0, 32'h0));                  // empty after clear
    send_item(make_item(FN_PUSH, 32'd5, 32'd7));
    send_item(make_item(FN_PUSH, 32'd6, 32'd7));
    send_item(make_item(FN_PUSH, 32'd7, 32'd7));
    // limit lowered below the count: entries stay, pushes bounce
    set_limit(5'd2);
    send_item(make_item(FN_PUSH, 32'd8, 32'h8000_0000));         // overflow
    send_item(make_item(FN_POP, 32'h0, 32'h0));
    send_item(make_item(FN_PUSH, 32'd9, 32'd1));                 // still full
    send_item(make_item(FN_POP, 32'h0, 32'h0));
    send_item(make_item(FN_PUSH, 32'd10, 32'd1));                // room again

    // ---- random phases ----
    // Lean and idling are redrawn every 50 items so both fill-to-full and
    // drain-to-empty stretches occur, with and without idle bursts. The last
    // phase runs with no idling on either side.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_limit(phase_limit[ph][CFG_W-1:0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          lean     = $urandom_range(0, 2);
          src_gaps = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
          snk_gaps = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        send_item(random_op(lean));
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_priority_queue_top verification clean");
    end else begin
      $display("sorted_priority_queue_top verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_priority_queue_top.sv
sim/spq_checker.sv
sim/sorted_priority_queue_top_tb.sv
